// File: src/bcev_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bcev_pkg
// Types and constants shared by the Bernstein curve evaluator: item payloads,
// sequencer states, fixed-point constants and the binomial coefficient table.
// ============================================================================
package bcev_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] t;
        logic [2:0]  basis_index;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               saturated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_USTEP,
        ST_BINOM,
        ST_MAC,
        ST_TSTEP,
        ST_DRAIN,
        ST_FINAL
    } state_t;

    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_BASIS = 1'b1;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_0 = 4'd1;

    localparam logic [15:0] T_ONE    = 16'd32768;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [63:0] ONE_Q16  = 64'd65536;

    // Shared multiplier: signed 25-bit operand times unsigned 31-bit operand.
    localparam int CHUNK_W   = 24;
    localparam int MUL_A_W   = CHUNK_W + 1;
    localparam int MUL_B_W   = 31;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 1;

    localparam logic [6:0][6:0][4:0] BINOM_TBL = '{
        '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6,  5'd1},
        '{5'd0, 5'd1, 5'd5,  5'd10, 5'd10, 5'd5,  5'd1},
        '{5'd0, 5'd0, 5'd1,  5'd4,  5'd6,  5'd4,  5'd1},
        '{5'd0, 5'd0, 5'd0,  5'd1,  5'd3,  5'd3,  5'd1},
        '{5'd0, 5'd0, 5'd0,  5'd0,  5'd1,  5'd2,  5'd1},
        '{5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd1,  5'd1},
        '{5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0,  5'd1}
    };

    // Binomial coefficient C(n, k) for n up to six; zero outside the table.
    // Row n holds C(n, k) at position n - k.
    function automatic logic [4:0] binom(input logic [2:0] n, input logic [2:0] k);
        logic [4:0] c;
        c = 5'd0;
        if (n != 3'd7 && k <= n)
        begin
            c = BINOM_TBL[n][n - k];
        end
        return c;
    endfunction

endpackage

// File: src/bernstein_curve_evaluator_unit.sv
`timescale 1ns / 1ps
// Evaluate mode, with effective degree n, multiplies each point in NCH =
// ceil(POINT_WIDTH/24) chunks, all on the single shared multiplier.
// Basis mode takes no chunks; an index above the degree goes straight to the result.
// A new item is taken only while the sequencer is idle, so each item is finished
// before the next is taken; the next is taken while a result still waits.
// Reset: degree 3, all points 1.0, sequencer idle, no result pending.
// ============================================================================
// bernstein_curve_evaluator_unit
// Evaluates a Bezier curve or one Bernstein basis polynomial at t by repeated
// fixed-point power steps, a binomial scaling and, for a curve, chunked multiply-accumulate,
// all on one shared multiplier under a small sequencer.
// ============================================================================
module bernstein_curve_evaluator_unit
    import bcev_pkg::*;
#(
    parameter int MAX_DEGREE  = 6,
    parameter int POINT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [POINT_WIDTH-1:0] cfg_data
);

    localparam int NPTS  = MAX_DEGREE + 1;
    localparam int KW    = $clog2(MAX_DEGREE + 1);
    localparam int NCH   = (POINT_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PX_W  = NCH * CHUNK_W;
    localparam int ACC_W = POINT_WIDTH + 34;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd536870912);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-64'sd2147483648);

    // Configuration registers
    logic [2:0]                    degree_reg;
    logic signed [POINT_WIDTH-1:0] point_reg [NPTS];

    // Sequencer and datapath registers
    state_t                     state_reg, state_next;
    logic                       mode_reg, mode_next;
    logic [15:0]                t_reg, t_next;
    logic [15:0]                u_reg, u_next;
    logic [2:0]                 idx_reg, idx_next;
    logic [KW-1:0]              n_reg, n_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [KW-1:0]              j_reg, j_next;
    logic [CHW-1:0]             ch_reg, ch_next;
    logic [MUL_B_W-1:0]         tpow_reg, tpow_next;
    logic [MUL_B_W-1:0]         p_reg, p_next;
    logic signed [MUL_P_W-1:0]  prod_reg, prod_next;
    logic                       pend_reg, pend_next;
    logic [CHW-1:0]             pend_ch_reg, pend_ch_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_data_reg, out_data_next;

    // Combinational helpers
    logic                       accept;
    logic [15:0]                t_clamped;
    logic [KW-1:0]              n_eff;
    logic                       cur_mode;
    logic [2:0]                 cur_idx;
    logic [KW-1:0]              cur_n;
    logic [KW-1:0]              entry_k;
    logic [KW-1:0]              entry_j;
    state_t                     entry_state;
    logic signed [PX_W-1:0]     pt_ext;
    logic [CHUNK_W-1:0]         chunk;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic signed [MUL_P_W-1:0]  mul_rnd;
    logic [MUL_B_W-1:0]         step_val;
    logic [MUL_B_W-1:0]         b_val;
    logic signed [ACC_W-1:0]    add_term;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ACC_W-1:0]    acc_res;
    logic [MUL_B_W-1:0]         basis_rnd;
    logic                       out_free;
    logic [CFG_IDX_W-1:0]       cfg_pidx;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign t_clamped = (in_data.t > T_ONE) ? T_ONE : in_data.t;
    assign n_eff     = (degree_reg > 3'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(degree_reg);

    // While idle, the fields of the arriving item decide the first step.
    assign cur_mode = (state_reg == ST_IDLE) ? in_data.mode        : mode_reg;
    assign cur_idx  = (state_reg == ST_IDLE) ? in_data.basis_index : idx_reg;
    assign cur_n    = (state_reg == ST_IDLE) ? n_eff               : n_reg;
    assign entry_k  = (state_reg == ST_TSTEP) ? k_reg + KW'(1) : '0;
    assign entry_j  = cur_n - entry_k;

    always_comb
    begin
        if (cur_mode == MODE_BASIS && 3'(entry_k) != cur_idx)
        begin
            entry_state = ST_TSTEP;
        end
        else if (entry_j == '0)
        begin
            entry_state = ST_BINOM;
        end
        else
        begin
            entry_state = ST_USTEP;
        end
    end

    // Shared multiplier operand selection.
    assign pt_ext = PX_W'(point_reg[k_reg]);
    assign chunk  = pt_ext[ch_reg * CHUNK_W +: CHUNK_W];

    always_comb
    begin
        unique case (state_reg)
            ST_USTEP: mul_a = MUL_A_W'(u_reg);
            ST_TSTEP: mul_a = MUL_A_W'(t_reg);
            ST_BINOM: mul_a = MUL_A_W'(binom(3'(n_reg), 3'(k_reg)));
            ST_MAC:
            begin
                // Only the top chunk of the point carries its sign.
                if (ch_reg == CHW'(NCH - 1))
                begin
                    mul_a = {chunk[CHUNK_W-1], chunk};
                end
                else
                begin
                    mul_a = {1'b0, chunk};
                end
            end
            default:  mul_a = '0;
        endcase
    end

    assign mul_b    = (state_reg == ST_TSTEP) ? tpow_reg : p_reg;
    assign mul_p    = mul_a * $signed({1'b0, mul_b});
    assign mul_rnd  = mul_p + MUL_P_W'(16384);
    assign step_val = mul_rnd[45:15];
    assign b_val    = (mul_p > $signed({{(MUL_P_W-MUL_B_W){1'b0}}, ONE_Q30}))
                      ? ONE_Q30 : mul_p[MUL_B_W-1:0];

    assign add_term  = ACC_W'(prod_reg) <<< (pend_ch_reg * CHUNK_W);
    assign acc_rnd   = acc_reg + ACC_HALF;
    assign acc_res   = acc_rnd >>> 30;
    assign basis_rnd = p_reg + MUL_B_W'(8192);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        ch_next        = ch_reg;
        tpow_next      = tpow_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        pend_next      = 1'b0;
        pend_ch_next   = pend_ch_reg;
        acc_next       = pend_reg ? acc_reg + add_term : acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = in_data.mode;
                    t_next    = t_clamped;
                    u_next    = T_ONE - t_clamped;
                    idx_next  = in_data.basis_index;
                    n_next    = n_eff;
                    k_next    = '0;
                    j_next    = entry_j;
                    tpow_next = ONE_Q30;
                    p_next    = ONE_Q30;
                    acc_next  = '0;
                    if (in_data.mode == MODE_BASIS && in_data.basis_index > 3'(n_eff))
                    begin
                        // An index above the degree gives a zero basis value.
                        p_next     = '0;
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = entry_state;
                    end
                end
            end
            ST_USTEP:
            begin
                p_next = step_val;
                j_next = j_reg - KW'(1);
                if (j_reg == KW'(1))
                begin
                    state_next = ST_BINOM;
                end
            end
            ST_BINOM:
            begin
                p_next = b_val;
                if (mode_reg == MODE_BASIS)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    ch_next    = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                prod_next    = mul_p;
                pend_next    = 1'b1;
                pend_ch_next = ch_reg;
                if (ch_reg == CHW'(NCH - 1))
                begin
                    state_next = (k_reg == n_reg) ? ST_DRAIN : ST_TSTEP;
                end
                else
                begin
                    ch_next = ch_reg + CHW'(1);
                end
            end
            ST_TSTEP:
            begin
                // The t power chain is shared by all basis terms.
                tpow_next  = step_val;
                p_next     = step_val;
                k_next     = entry_k;
                j_next     = entry_j;
                state_next = entry_state;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_BASIS)
                    begin
                        out_data_next.value     = 32'(basis_rnd[30:14]);
                        out_data_next.saturated = 1'b0;
                    end
                    else if (acc_res > SAT_HI)
                    begin
                        out_data_next.value     = 32'sh7FFF_FFFF;
                        out_data_next.saturated = 1'b1;
                    end
                    else if (acc_res < SAT_LO)
                    begin
                        out_data_next.value     = 32'sh8000_0000;
                        out_data_next.saturated = 1'b1;
                    end
                    else
                    begin
                        out_data_next.value     = acc_res[31:0];
                        out_data_next.saturated = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        t_reg        <= t_next;
        u_reg        <= u_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        ch_reg       <= ch_next;
        tpow_reg     <= tpow_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        pend_ch_reg  <= pend_ch_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // Configuration writes; indexes past the stored points are dropped.
    assign cfg_pidx = cfg_index - CFG_POINT_0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= 3'd3;
            for (int i = 0; i < NPTS; i++)
            begin
                point_reg[i] <= POINT_WIDTH'(ONE_Q16);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DEGREE)
            begin
                degree_reg <= cfg_data[2:0];
            end
            else if (cfg_pidx < CFG_IDX_W'(NPTS))
            begin
                point_reg[KW'(cfg_pidx)] <= cfg_data;
            end
        end
    end

endmodule

// File: verif/bernstein_curve_evaluator_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// bernstein_curve_evaluator_unit_tb
// Self-checking bench for the Bernstein curve evaluator. A bit-exact predictor
// computes each curve point or basis value as items are accepted; the monitor
// compares results in order. Register settings change between idle phases,
// and both sides of the item handshake idle and stall at random.
// ============================================================================
module bernstein_curve_evaluator_unit_tb;
    import bcev_pkg::*;

    localparam int NUM_POINTS     = 7;
    localparam int LATENCY_MARGIN = 60;
    localparam int NUM_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam logic [CFG_IDX_W-1:0] CFG_PAST_LIST = CFG_POINT_0 + CFG_IDX_W'(NUM_POINTS);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = '1;
    localparam logic signed [95:0] Q16_MAX = 96'sd2147483647;
    localparam logic signed [95:0] Q16_MIN = -96'sd2147483648;
    localparam logic [31:0] PT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PT_MIN = 32'h8000_0000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    // Register copy used by the predictor.
    logic [2:0]  degree_shadow;
    logic [31:0] point_shadow [NUM_POINTS];

    in_item_t  pending_items [$];
    out_item_t expected_points [$];

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int stall_style = 0;
    int style_left = 0;
    int stall_phase = 0;

    int items_sent = 0;
    int basis_items = 0;
    int results_seen = 0;
    int clipped_results = 0;
    int mismatches = 0;
    int failures = 0;
    int settings_used = 1;
    out_item_t want;

    bernstein_curve_evaluator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] n_choose_k(int n, int k);
        logic [63:0] c;
        int i;
        c = 64'd1;
        for (i = 0; i < k; i++)
        begin
            c = c * (n - i) / (i + 1);
        end
        return c;
    endfunction

    // Basis value C(n,k) * t^k * (1-t)^(n-k) in unsigned Q.30, rounded per step.
    function automatic logic [63:0] basis_q30(logic [15:0] tv, int k, int n);
        logic [63:0] p;
        logic [63:0] uv;
        logic [63:0] b;
        int j;
        if (k > n)
        begin
            return 64'd0;
        end
        uv = 64'd32768 - 64'(tv);
        p = 64'd1 << 30;
        for (j = 0; j < k; j++)
        begin
            p = (p * 64'(tv) + 64'd16384) >> 15;
        end
        for (j = 0; j < n - k; j++)
        begin
            p = (p * uv + 64'd16384) >> 15;
        end
        b = n_choose_k(n, k) * p;
        if (b > (64'd1 << 30))
        begin
            b = 64'd1 << 30;
        end
        return b;
    endfunction

    function automatic out_item_t curve_value(in_item_t it);
        out_item_t res;
        logic [15:0] tc;
        logic [63:0] b;
        logic [63:0] bv;
        logic signed [95:0] acc;
        logic signed [95:0] r;
        int n;
        int k;
        n = (degree_shadow > 3'd6) ? 6 : int'(degree_shadow);
        tc = (it.t > T_ONE) ? T_ONE : it.t;
        res = '0;
        if (it.mode == MODE_BASIS)
        begin
            b = basis_q30(tc, int'(it.basis_index), n);
            bv = (b + 64'd8192) >> 14;
            res.value = bv[31:0];
            res.saturated = 1'b0;
        end
        else
        begin
            acc = '0;
            for (k = 0; k <= n; k++)
            begin
                b = basis_q30(tc, k, n);
                acc = acc + $signed({{64{point_shadow[k][31]}}, point_shadow[k]})
                          * $signed({32'd0, b});
            end
            acc = acc + 96'sd536870912;
            r = acc >>> 30;
            if (r > Q16_MAX)
            begin
                res.value = PT_MAX;
                res.saturated = 1'b1;
            end
            else if (r < Q16_MIN)
            begin
                res.value = PT_MIN;
                res.saturated = 1'b1;
            end
            else
            begin
                res.value = r[31:0];
                res.saturated = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic in_item_t make_item(logic m, logic [15:0] tv, logic [2:0] idx);
        in_item_t it;
        it.mode = m;
        it.t = tv;
        it.basis_index = idx;
        return it;
    endfunction

    // Mostly legal t, with the ends of the range and out-of-range values mixed in.
    function automatic logic [15:0] pick_t();
        int sel;
        logic [15:0] tv;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            tv = 16'($urandom_range(0, 32768));
        end
        else if (sel < 8)
        begin
            case ($urandom_range(0, 3))
                0: tv = 16'd0;
                1: tv = T_ONE;
                2: tv = 16'd1;
                default: tv = T_ONE - 16'd1;
            endcase
        end
        else
        begin
            tv = 16'($urandom_range(0, 65535));
        end
        return tv;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_points.push_back(curve_value(in_data));
                items_sent++;
                if (in_data.mode == MODE_BASIS)
                begin
                    basis_items++;
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            stall_style = 0;
            style_left = 0;
            stall_phase = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    failures++;
                    if (mismatches + failures <= 10)
                    begin
                        $display("Unexpected result: value %0d saturated %0b",
                                 out_data.value, out_data.saturated);
                    end
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (out_data.value !== want.value || out_data.saturated !== want.saturated)
                    begin
                        mismatches++;
                        if (mismatches + failures <= 10)
                        begin
                            $display("Mismatch on result %0d: value exp %0d got %0d, saturated exp %0b got %0b",
                                     results_seen, want.value, out_data.value,
                                     want.saturated, out_data.saturated);
                        end
                    end
                end
                if (out_data.saturated === 1'b1)
                begin
                    clipped_results++;
                end
                results_seen++;
                // A long hold-off lets the block fill up and stall its input.
                if (results_seen == 300 || results_seen == 1100)
                begin
                    hold_left = 400;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    stall_style = $urandom_range(0, 3);
                    style_left = $urandom_range(50, 200);
                end
                style_left--;
                stall_phase = (stall_phase + 1) % 3;
                case (stall_style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= ($urandom_range(0, 9) < 8);
                    default: out_stall <= (stall_phase == 0);
                endcase
            end
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_DEGREE)
        begin
            degree_shadow = data[2:0];
        end
        else if (idx >= CFG_POINT_0 && idx < CFG_PAST_LIST)
        begin
            point_shadow[idx - CFG_POINT_0] = data;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_points.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int phase;
        int i;
        int pattern;
        logic [31:0] pv;
        logic [2:0] deg;
        degree_shadow = 3'd3;
        for (i = 0; i < NUM_POINTS; i++)
        begin
            point_shadow[i] = 32'd65536;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed items under the reset settings: ends of t, clamping of t,
        // every basis index including those above the degree.
        pending_items.push_back(make_item(MODE_EVAL, 16'd0, 3'd0));
        pending_items.push_back(make_item(MODE_EVAL, T_ONE, 3'd0));
        pending_items.push_back(make_item(MODE_EVAL, 16'd16384, 3'd0));
        pending_items.push_back(make_item(MODE_EVAL, 16'd1, 3'd7));
        pending_items.push_back(make_item(MODE_EVAL, T_ONE - 16'd1, 3'd0));
        pending_items.push_back(make_item(MODE_EVAL, 16'hFFFF, 3'd5));
        pending_items.push_back(make_item(MODE_EVAL, T_ONE + 16'd1, 3'd0));
        for (i = 0; i < 8; i++)
        begin
            pending_items.push_back(make_item(MODE_BASIS, 16'd12345, 3'(i)));
        end
        pending_items.push_back(make_item(MODE_BASIS, 16'd0, 3'd0));
        pending_items.push_back(make_item(MODE_BASIS, T_ONE, 3'd3));
        pending_items.push_back(make_item(MODE_BASIS, 16'hFFFF, 3'd3));
        pending_items.push_back(make_item(MODE_BASIS, 16'h7FFF, 3'd1));
        wait_until_drained();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Each degree code once in the first eight phases, including the one above the maximum.
            deg = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            pv = $urandom();
            write_register(CFG_DEGREE, {pv[31:3], deg});
            pattern = phase % 6;
            for (i = 0; i < NUM_POINTS; i++)
            begin
                case (pattern)
                    1: pv = PT_MAX;
                    2: pv = PT_MIN;
                    3: pv = (i % 2 == 0) ? PT_MAX : PT_MIN;
                    4: pv = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
                    default: pv = $urandom();
                endcase
                write_register(CFG_POINT_0 + CFG_IDX_W'(i), pv);
            end
            if (phase == 5)
            begin
                // Indexes past the list must leave every register alone.
                write_register(CFG_PAST_LIST, $urandom());
                write_register(CFG_TOP_INDEX, $urandom());
            end
            settings_used++;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pending_items.push_back(make_item(1'($urandom_range(0, 1)), pick_t(),
                                                  3'($urandom_range(0, 7))));
            end
            wait_until_drained();
        end

        repeat (LATENCY_MARGIN) @(posedge clk);
        $display("Covered %0d items (%0d basis, %0d curve) over %0d register settings;",
                 items_sent, basis_items, items_sent - basis_items, settings_used);
        $display("%0d results checked, %0d of them clipped.", results_seen, clipped_results);
        if (mismatches == 0 && failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("Timed out with %0d results outstanding.", expected_points.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
src/bcev_pkg.sv
src/bernstein_curve_evaluator_unit.sv
verif/bernstein_curve_evaluator_unit_tb.sv
